// ===== rtl/cpx3_pkg.sv =====
// Package for the charlieplexed three-digit scan unit: drive codes and segment tables.
package cpx3_pkg;

    localparam int unsigned PinCount   = 5;
    localparam int unsigned PhaseWidth = 2;

    // Drive codes for one pin.
    localparam logic [1:0] DRV_Z = 2'd0;
    localparam logic [1:0] DRV_L = 2'd1;
    localparam logic [1:0] DRV_H = 2'd2;

    // Segment table of the hundreds position: only digit 1 lights.
    function automatic logic [15:0] hund_seg(input logic [1:0] digit);
        logic [15:0] seg;
        case (digit)
            2'd1:    seg = 16'h0006;
            default: seg = 16'h0000;
        endcase
        return seg;
    endfunction

    function automatic logic [15:0] tens_seg(input logic [3:0] digit);
        logic [15:0] seg;
        case (digit)
            4'd0:    seg = 16'h0770;
            4'd1:    seg = 16'h0420;
            4'd2:    seg = 16'h0741;
            4'd3:    seg = 16'h0661;
            4'd4:    seg = 16'h0431;
            4'd5:    seg = 16'h0271;
            4'd6:    seg = 16'h0371;
            4'd7:    seg = 16'h0460;
            4'd8:    seg = 16'h0771;
            4'd9:    seg = 16'h0671;
            default: seg = 16'h0000;
        endcase
        return seg;
    endfunction

    function automatic logic [15:0] ones_seg(input logic [3:0] digit);
        logic [15:0] seg;
        case (digit)
            4'd0:    seg = 16'hE888;
            4'd1:    seg = 16'h8080;
            4'd2:    seg = 16'hD808;
            4'd3:    seg = 16'hD880;
            4'd4:    seg = 16'hB080;
            4'd5:    seg = 16'h7880;
            4'd6:    seg = 16'h7888;
            4'd7:    seg = 16'h8880;
            4'd8:    seg = 16'hF888;
            4'd9:    seg = 16'hF880;
            default: seg = 16'h0000;
        endcase
        return seg;
    endfunction

endpackage

// ===== rtl/cpx3_if.sv =====
// Request channel interfaces of the charlieplexed three-digit scan unit.
interface cpx3_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface cpx3_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] pin1_drive;
    logic [1:0] pin2_drive;
    logic [1:0] pin3_drive;
    logic [1:0] pin4_drive;
    logic [1:0] pin5_drive;
    logic [1:0] scan_phase;

    modport source (
        output valid, output pin1_drive, output pin2_drive, output pin3_drive,
        output pin4_drive, output pin5_drive, output scan_phase, input ready
    );
    modport sink (
        input valid, input pin1_drive, input pin2_drive, input pin3_drive,
        input pin4_drive, input pin5_drive, input scan_phase, output ready
    );
endinterface

// ===== rtl/charlieplex_three_digit_scan_unit.sv =====
// Top level of the charlieplexed three-digit scan unit.
//
//  Channel   Dir  Payload                                   Accepted when
//  i_in      in   value[7:0]                                valid && ready
//  o_out     out  pin1..pin5_drive[1:0], scan_phase[1:0]    valid && ready
//
// A request is registered at the input, its pattern is decoded and mapped onto
// the pins in one pass of logic, and the result is registered at the output.
// The result is shown once its request has moved from the input register into
// the output register, which it does when that register is free; one request
// can be accepted every cycle while the output keeps moving.
// A stalled output holds its result while one more request waits in the input
// register; the input is ready whenever that register is empty or moving on.
// Reset (synchronous, active low) empties both registers and sets the scan
// phase to zero.
module charlieplex_three_digit_scan_unit
    import cpx3_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    cpx3_in_if.sink           i_in,
    cpx3_out_if.source        o_out
);

    // Input register stage.
    logic       r_in_valid;
    logic [7:0] r_value;

    // Output register stage.
    logic       r_out_valid;
    logic [1:0] r_drive [PinCount];
    logic [1:0] r_out_phase;

    // Phase that the next request moving into the output register will use.
    logic [PhaseWidth-1:0] r_phase;
    logic [PhaseWidth-1:0] n_phase;

    logic        out_free;
    logic        advance;
    logic        in_take;
    logic [15:0] pattern;
    logic [3:0]  nib;
    logic [1:0]  drive [PinCount];

    // The output register can be loaded when empty or when its result leaves.
    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && out_free;
    assign in_take  = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || out_free;
    assign n_phase  = r_phase + 1'b1;

    cpx3_seg_lookup u_seg_lookup (
        .i_value   (r_value),
        .o_pattern (pattern)
    );

    // The current phase selects one nibble of the pattern. Its bits, most
    // significant first, drive the four pins other than the low one in
    // ascending pin order.
    always_comb begin
        case (r_phase)
            2'd0:    nib = pattern[15:12];
            2'd1:    nib = pattern[11:8];
            2'd2:    nib = pattern[7:4];
            default: nib = pattern[3:0];
        endcase
        for (int j = 0; j < PinCount; j++) begin
            if (j == int'(r_phase)) begin
                drive[j] = DRV_L;
            end else if (j < int'(r_phase)) begin
                drive[j] = nib[2'(3 - j)] ? DRV_H : DRV_Z;
            end else begin
                drive[j] = nib[2'(4 - j)] ? DRV_H : DRV_Z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_value <= i_in.value;
        end
        if (advance) begin
            r_drive     <= drive;
            r_out_phase <= r_phase;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pin1_drive = r_drive[0];
    assign o_out.pin2_drive = r_drive[1];
    assign o_out.pin3_drive = r_drive[2];
    assign o_out.pin4_drive = r_drive[3];
    assign o_out.pin5_drive = r_drive[4];
    assign o_out.scan_phase = r_out_phase;

`ifndef ASSERT_OFF
    // The phase steps by one for every request that reaches the output register.
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_phase == $past(n_phase))
        else $error("scan phase did not advance by one");

    // Pin 5 is never pulled low.
    a_pin5_never_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_drive[4] != DRV_L)
        else $error("pin 5 driven low");

    // The pin selected by the shown phase is the one driven low.
    a_low_pin_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_drive[r_out_phase] == DRV_L)
        else $error("low pin does not match scan phase");

    // A waiting request is never dropped while the output is stalled.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> r_in_valid && $stable(r_value))
        else $error("input register overwritten while stalled");
`endif

endmodule

// ===== rtl/cpx3_seg_lookup.sv =====
// Digit split of an 8-bit value and lookup of the lit-segment pattern.
module cpx3_seg_lookup
    import cpx3_pkg::*;
(
    input  logic [7:0]  i_value,
    output logic [15:0] o_pattern
);

    logic [1:0]  hund;
    logic [7:0]  rem_full;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones_full;
    logic [3:0]  ones;

    always_comb begin
        if (i_value >= 8'd200) begin
            hund     = 2'd2;
            rem_full = i_value - 8'd200;
        end else if (i_value >= 8'd100) begin
            hund     = 2'd1;
            rem_full = i_value - 8'd100;
        end else begin
            hund     = 2'd0;
            rem_full = i_value;
        end
        rem = rem_full[6:0];
        // Multiplying by 205/2048 gives the exact quotient by ten for values below 100.
        prod      = {8'd0, rem} * 15'd205;
        tens      = prod[14:11];
        tens_x10  = {3'd0, tens} * 7'd10;
        ones_full = rem - tens_x10;
        ones      = ones_full[3:0];
        o_pattern = hund_seg(hund) | tens_seg(tens) | ones_seg(ones);
    end

endmodule

// ===== tb/charlieplex_three_digit_scan_unit_tb.sv =====
// Self-checking testbench of the charlieplexed three-digit scan unit.
`timescale 1ns / 100ps

module charlieplex_three_digit_scan_unit_tb;
    import cpx3_pkg::*;

    // Lit-segment patterns of one digit position. The hundreds position lights
    // only for a digit of one; every other hundreds digit leaves it blank.
    localparam logic [15:0] HUNDREDS_ONE_LIT = 16'h0006;
    localparam logic [15:0] TENS_LIT [10] = '{
        16'h0770, 16'h0420, 16'h0741, 16'h0661, 16'h0431,
        16'h0271, 16'h0371, 16'h0460, 16'h0771, 16'h0671
    };
    localparam logic [15:0] ONES_LIT [10] = '{
        16'hE888, 16'h8080, 16'hD808, 16'hD880, 16'hB080,
        16'h7880, 16'h7888, 16'h8880, 16'hF888, 16'hF880
    };

    localparam int unsigned RANDOM_TICKS  = 850;
    localparam int unsigned LONG_HOLD_AT  = 150;  // result count that starts the long stall
    localparam int unsigned LONG_HOLD_LEN = 80;   // cycles the receiver holds off
    localparam int unsigned IDLE_LIMIT    = 1000; // cycles without any handshake
    localparam int unsigned TAIL_CYCLES   = 8;    // cycles waited after the queues run empty
    localparam int unsigned MAX_PRINTS    = 40;

    // One refresh tick waiting to be sent. The gap is the number of idle
    // cycles before it is offered; a drain tick is held back until every
    // expected pin pattern has come out.
    typedef struct {
        logic [7:0]  value;
        int unsigned gap;
        bit          drain;
    } t_tick;

    // The pin drives and scan phase of one tick, as the block should show them.
    typedef struct packed {
        logic [1:0] pin1;
        logic [1:0] pin2;
        logic [1:0] pin3;
        logic [1:0] pin4;
        logic [1:0] pin5;
        logic [1:0] phase;
    } t_pin_set;

    logic i_clk;
    logic i_rst_n;

    cpx3_in_if  in_if ();
    cpx3_out_if out_if ();

    charlieplex_three_digit_scan_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_tick       tick_q [$];
    t_pin_set    pin_set_q [$];
    logic [1:0]  scan_phase;
    int unsigned error_count;
    int unsigned ticks_sent;
    int unsigned patterns_seen;
    int unsigned send_wait;
    bit          send_armed;
    int unsigned recv_wait;
    bit          long_hold_done;
    int unsigned idle_cycles;
    bit [3:0]    phases_seen;

    // Works out the pin drives for one tick. The value is split into decimal
    // digits, the three patterns are ORed, and the nibble of the current phase
    // is mapped onto the four pins that are not pulled low. Pin 5 is never the
    // low pin, so it is only ever high or floating.
    function automatic t_pin_set scan_pins(input logic [7:0] value, input logic [1:0] phase);
        logic [15:0] lit;
        logic [3:0]  nib;
        logic [1:0]  drive [5];
        int unsigned hundreds;
        int unsigned tens;
        int unsigned ones;
        int unsigned pin;
        t_pin_set    res;
        hundreds = value / 100;
        tens     = (value % 100) / 10;
        ones     = value % 10;
        // The tens pattern is always used, so a tens digit of zero shows as
        // zero even when the hundreds position is blank.
        lit = TENS_LIT[tens] | ONES_LIT[ones];
        if (hundreds == 1) begin
            lit = lit | HUNDREDS_ONE_LIT;
        end
        case (phase)
            2'd0:    nib = lit[15:12];
            2'd1:    nib = lit[11:8];
            2'd2:    nib = lit[7:4];
            default: nib = lit[3:0];
        endcase
        for (int k = 0; k < 5; k++) begin
            drive[k] = DRV_Z;
        end
        drive[phase] = DRV_L;
        // The most significant nibble bit drives the lowest numbered free pin.
        for (int k = 0; k < 4; k++) begin
            pin = (k < phase) ? k : k + 1;
            if (nib[3 - k]) begin
                drive[pin] = DRV_H;
            end
        end
        res.pin1  = drive[0];
        res.pin2  = drive[1];
        res.pin3  = drive[2];
        res.pin4  = drive[3];
        res.pin5  = drive[4];
        res.phase = phase;
        return res;
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string field, input logic [1:0] got,
                               input logic [1:0] want);
        if (got !== want) begin
            report_error($sformatf("result %0d %s: got %0d, expected %0d",
                                   patterns_seen, field, got, want));
        end
    endtask

    task automatic add_tick(input logic [7:0] value, input int unsigned gap,
                            input bit drain);
        t_tick t;
        t.value = value;
        t.gap   = gap;
        t.drain = drain;
        tick_q.push_back(t);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver. It offers the head of the tick queue once its gap has run out,
    // holds it while the block stalls, and predicts the pin pattern of every
    // request that the block accepts. The scan phase advances on each
    // accepted request and wraps from three to zero.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.value <= '0;
            scan_phase  = '0;
            send_armed  = 1'b0;
            send_wait   = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                pin_set_q.push_back(scan_pins(in_if.value, scan_phase));
                scan_phase = scan_phase + 2'd1;
                ticks_sent++;
                void'(tick_q.pop_front());
                send_armed = 1'b0;
            end
            if (!(in_if.valid && !in_if.ready)) begin
                // Either nothing is on offer or the last request just went
                // through, so the next one may be put up in this step.
                if (!send_armed && tick_q.size() > 0) begin
                    send_wait  = tick_q[0].gap;
                    send_armed = 1'b1;
                end
                if (send_armed && send_wait > 0) begin
                    send_wait--;
                    in_if.valid <= 1'b0;
                end else if (send_armed && !(tick_q[0].drain && pin_set_q.size() > 0)) begin
                    in_if.valid <= 1'b1;
                    in_if.value <= tick_q[0].value;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each accepted result is compared with the oldest prediction,
    // and the ready it shows for the next result is drawn here too. Once in
    // the run it holds off for a long stretch so that both registers of the
    // block fill and the input stalls; for a while it never stalls at all.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready   <= 1'b0;
            recv_wait      = 0;
            long_hold_done = 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pin_set_q.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing expected",
                                           patterns_seen));
                end else begin
                    check_field("pin1_drive", out_if.pin1_drive, pin_set_q[0].pin1);
                    check_field("pin2_drive", out_if.pin2_drive, pin_set_q[0].pin2);
                    check_field("pin3_drive", out_if.pin3_drive, pin_set_q[0].pin3);
                    check_field("pin4_drive", out_if.pin4_drive, pin_set_q[0].pin4);
                    check_field("pin5_drive", out_if.pin5_drive, pin_set_q[0].pin5);
                    check_field("scan_phase", out_if.scan_phase, pin_set_q[0].phase);
                    phases_seen[pin_set_q[0].phase] = 1'b1;
                    void'(pin_set_q.pop_front());
                end
                patterns_seen++;
                if (patterns_seen >= 500 && patterns_seen < 620) begin
                    recv_wait = 0;
                end else begin
                    recv_wait = $urandom_range(0, 4);
                end
                if (!long_hold_done && patterns_seen >= LONG_HOLD_AT) begin
                    recv_wait      = LONG_HOLD_LEN;
                    long_hold_done = 1'b1;
                end
            end
            if (recv_wait > 0) begin
                recv_wait--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run if no handshake happens on either side for too long.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] ERROR: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
            $display("FAIL charlieplex_three_digit_scan_unit");
            $finish;
        end
    end

    initial begin
        logic [7:0] directed [] = '{
            8'd0,   8'd255, 8'd7,   8'd10,  8'd23,  8'd34,  8'd45,  8'd56,
            8'd67,  8'd78,  8'd89,  8'd91,  8'd100, 8'd101, 8'd109, 8'd110,
            8'd128, 8'd199, 8'd200, 8'd202, 8'd205, 8'd210, 8'd250, 8'd254
        };
        int unsigned gap;
        logic [7:0]  value;

        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.value    = '0;
        out_if.ready   = 1'b0;
        error_count    = 0;
        ticks_sent     = 0;
        patterns_seen  = 0;
        idle_cycles    = 0;
        phases_seen    = '0;

        // Directed part: both ends of the range, every ones and tens digit,
        // hundreds digits of zero, one and two (two shows blank), and a tens
        // digit of zero under a blank hundreds position. The run of ticks
        // also walks the scan phase through its wrap several times.
        foreach (directed[i]) begin
            add_tick(directed[i], $urandom_range(0, 4), 1'b0);
        end

        // Random part. The first tick after the directed part, and one in
        // the middle, wait until the block has drained completely.
        for (int i = 0; i < RANDOM_TICKS; i++) begin
            if (i >= 250 && i < 350) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 4);
            end
            // A quarter of the values are drawn from the hundred range, where the
            // hundreds position lights.
            if ($urandom_range(0, 3) == 0) begin
                value = 8'($urandom_range(100, 199));
            end else begin
                value = 8'($urandom_range(0, 255));
            end
            add_tick(value, gap, (i == 0) || (i == 400));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (tick_q.size() != 0 || pin_set_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pin_set_q.size() != 0) begin
            report_error($sformatf("%0d results never arrived", pin_set_q.size()));
        end

        $display("Sent %0d refresh ticks (directed digit cases and random values) and checked",
                 ticks_sent);
        $display("%0d pin patterns over scan phases %b, with a long output stall and drains.",
                 patterns_seen, phases_seen);
        if (error_count == 0) begin
            $display("PASS charlieplex_three_digit_scan_unit");
        end else begin
            $display("FAIL charlieplex_three_digit_scan_unit");
        end
        $finish;
    end

endmodule
